@@ hw/rtl/aosnp_pkg.sv @@
package aosnp_pkg;

    // Operation codes carried on the func field.
    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_CREATE = 3'd1,
        OP_BEST   = 3'd2,
        OP_CLOSE  = 3'd3,
        OP_REOPEN = 3'd4,
        OP_LOOKUP = 3'd5
    } op_t;

    localparam logic [9:0] PARENT_NONE = 10'd512;

    // One stored node, kept as a single memory word.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [23:0] cost;
        logic [23:0] heur;
        logic [15:0] extra;
        logic [9:0]  parent;
        logic        open;
    } node_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RMW,
        ST_SCAN,
        ST_RESULT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic apply;
        logic rmw_rd;
        logic rmw_wr;
        logic scan_init;
        logic scan_step;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic idx_ok;
        logic scan_end;
        logic out_free;
    } dp_stat_t;

endpackage

@@ hw/rtl/astar_open_set_node_pool.sv @@
// Each input is latched, then start, create and unused codes are applied, close and reopen
// read the node and write it back, and best and lookup scan the pool; the result is then
// registered once the output register is free. Best and lookup read every allocated node
// through the memory read port, one node per cycle; a new input is taken in the cycle after
// the result is registered. Reset (synchronous, active low) empties the pool and clears the
// output valid; node memory contents are not cleared since only allocated nodes are ever read.
module astar_open_set_node_pool #(
    parameter int NODES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [23:0] s_cost_so_far,
    input  logic [23:0] s_heuristic_cost,
    input  logic [15:0] s_extra_cost,
    input  logic [9:0]  s_parent_index,
    input  logic [8:0]  s_node_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [8:0]  m_found_index,
    output logic [15:0] m_node_x,
    output logic [15:0] m_node_y,
    output logic [23:0] m_node_cost,
    output logic [23:0] m_node_heuristic,
    output logic [15:0] m_node_extra,
    output logic [9:0]  m_node_parent,
    output logic [9:0]  m_closed_count,
    output logic [9:0]  m_used_count
);
    import aosnp_pkg::*;

    // The controller sequences each operation; the datapath owns the node memory,
    // the pool counters, the scan pipeline and the output register.
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    aosnp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // A finished result waits in the output register while the next transfer is accepted.
    aosnp_dp #(
        .NODES (NODES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_func           (s_func),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_cost_so_far    (s_cost_so_far),
        .s_heuristic_cost (s_heuristic_cost),
        .s_extra_cost     (s_extra_cost),
        .s_parent_index   (s_parent_index),
        .s_node_index     (s_node_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_found_index    (m_found_index),
        .m_node_x         (m_node_x),
        .m_node_y         (m_node_y),
        .m_node_cost      (m_node_cost),
        .m_node_heuristic (m_node_heuristic),
        .m_node_extra     (m_node_extra),
        .m_node_parent    (m_node_parent),
        .m_closed_count   (m_closed_count),
        .m_used_count     (m_used_count)
    );

endmodule

@@ hw/rtl/aosnp_ctrl.sv @@
module aosnp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  aosnp_pkg::dp_stat_t   stat,
    output aosnp_pkg::ctrl_cmd_t  cmd
);
    import aosnp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (stat.op)
                    OP_BEST, OP_LOOKUP: state_next = ST_SCAN;
                    OP_CLOSE, OP_REOPEN: state_next = stat.idx_ok ? ST_RMW : ST_RESULT;
                    default: state_next = ST_RESULT;
                endcase
            end
            ST_RMW: state_next = ST_RESULT;
            ST_SCAN: begin
                if (stat.scan_end) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            ST_EXEC: begin
                unique case (stat.op)
                    OP_BEST, OP_LOOKUP: cmd.scan_init = 1'b1;
                    OP_CLOSE, OP_REOPEN: begin
                        cmd.rmw_rd = stat.idx_ok;
                        cmd.apply  = !stat.idx_ok;
                    end
                    default: cmd.apply = 1'b1;
                endcase
            end
            ST_RMW:    cmd.rmw_wr    = 1'b1;
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_RESULT: cmd.load_out  = stat.out_free;
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/aosnp_dp.sv @@
module aosnp_dp #(
    parameter int NODES = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  aosnp_pkg::ctrl_cmd_t  cmd,
    output aosnp_pkg::dp_stat_t   stat,
    input  logic [2:0]            s_func,
    input  logic [15:0]           s_pos_x,
    input  logic [15:0]           s_pos_y,
    input  logic [23:0]           s_cost_so_far,
    input  logic [23:0]           s_heuristic_cost,
    input  logic [15:0]           s_extra_cost,
    input  logic [9:0]            s_parent_index,
    input  logic [8:0]            s_node_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ok,
    output logic [8:0]            m_found_index,
    output logic [15:0]           m_node_x,
    output logic [15:0]           m_node_y,
    output logic [23:0]           m_node_cost,
    output logic [23:0]           m_node_heuristic,
    output logic [15:0]           m_node_extra,
    output logic [9:0]            m_node_parent,
    output logic [9:0]            m_closed_count,
    output logic [9:0]            m_used_count
);
    import aosnp_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    node_word_t mem [NODES];

    op_t         op_reg;
    logic [15:0] x_reg, y_reg, extra_reg;
    logic [23:0] cost_reg, heur_reg;
    logic [9:0]  parent_reg;
    logic [8:0]  idx_reg;

    logic [CW-1:0] used_reg, used_next, closed_reg, closed_next, cnt_reg, cnt_next;
    logic          pv_reg, pv_next;
    logic [AW-1:0] pa_reg, pa_next;
    node_word_t    rd_data_reg;

    logic          res_ok_reg, res_ok_next;
    logic [AW-1:0] res_idx_reg, res_idx_next;
    node_word_t    res_word_reg, res_word_next;
    logic [24:0]   res_sum_reg, res_sum_next;

    logic          m_valid_reg, m_valid_next;
    logic          m_ok_reg;
    logic [8:0]    m_idx_reg;
    node_word_t    m_word_reg;
    logic [9:0]    m_closed_reg, m_used_reg;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    node_word_t    wr_data, new_word;
    logic          full, idx_ok, scan_end;
    logic [24:0]   cand_sum;

    assign full     = 32'(used_reg) >= NODES;
    assign idx_ok   = 32'(idx_reg) < 32'(used_reg);
    assign scan_end = cnt_reg >= used_reg;
    assign cand_sum = {1'b0, rd_data_reg.cost} + {1'b0, rd_data_reg.heur};

    assign stat.op       = op_reg;
    assign stat.idx_ok   = idx_ok;
    assign stat.scan_end = scan_end;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        new_word.x      = x_reg;
        new_word.y      = y_reg;
        new_word.cost   = (op_reg == OP_START) ? 24'd0 : cost_reg;
        new_word.heur   = (op_reg == OP_START) ? 24'd0 : heur_reg;
        new_word.extra  = extra_reg;
        new_word.parent = (op_reg == OP_START) ? PARENT_NONE : parent_reg;
        new_word.open   = 1'b1;
    end

    always_comb begin
        used_next     = used_reg;
        closed_next   = closed_reg;
        cnt_next      = cnt_reg;
        pv_next       = 1'b0;
        pa_next       = pa_reg;
        res_ok_next   = res_ok_reg;
        res_idx_next  = res_idx_reg;
        res_word_next = res_word_reg;
        res_sum_next  = res_sum_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = new_word;
        rd_en         = 1'b0;
        rd_addr       = cnt_reg[AW-1:0];

        if (cmd.apply) begin
            res_ok_next = 1'b0;
            case (op_reg)
                OP_START: begin
                    wr_en         = 1'b1;
                    used_next     = CW'(1);
                    closed_next   = '0;
                    res_ok_next   = 1'b1;
                    res_idx_next  = '0;
                    res_word_next = new_word;
                end
                OP_CREATE: begin
                    if (!full) begin
                        wr_en         = 1'b1;
                        wr_addr       = used_reg[AW-1:0];
                        used_next     = used_reg + CW'(1);
                        res_ok_next   = 1'b1;
                        res_idx_next  = used_reg[AW-1:0];
                        res_word_next = new_word;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.rmw_rd) begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_reg);
        end

        if (cmd.rmw_wr) begin
            wr_en        = 1'b1;
            wr_addr      = AW'(idx_reg);
            wr_data      = rd_data_reg;
            wr_data.open = (op_reg == OP_REOPEN);
            if (op_reg == OP_CLOSE) begin
                if (rd_data_reg.open) closed_next = closed_reg + CW'(1);
            end else if (!rd_data_reg.open && closed_reg != '0) begin
                closed_next = closed_reg - CW'(1);
            end
            res_ok_next   = 1'b1;
            res_idx_next  = AW'(idx_reg);
            res_word_next = rd_data_reg;
        end

        if (cmd.scan_init) begin
            cnt_next    = '0;
            res_ok_next = 1'b0;
        end

        // Compare the word read in the previous cycle against the current pick.
        if (pv_reg) begin
            if (op_reg == OP_BEST) begin
                if (rd_data_reg.open && (!res_ok_reg || cand_sum < res_sum_reg)) begin
                    res_ok_next   = 1'b1;
                    res_idx_next  = pa_reg;
                    res_word_next = rd_data_reg;
                    res_sum_next  = cand_sum;
                end
            end else if (!res_ok_reg && rd_data_reg.x == x_reg && rd_data_reg.y == y_reg) begin
                res_ok_next   = 1'b1;
                res_idx_next  = pa_reg;
                res_word_next = rd_data_reg;
            end
        end

        if (cmd.scan_step && !scan_end) begin
            rd_en    = 1'b1;
            pv_next  = 1'b1;
            pa_next  = cnt_reg[AW-1:0];
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            closed_reg  <= '0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            closed_reg  <= closed_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        pa_reg       <= pa_next;
        res_ok_reg   <= res_ok_next;
        res_idx_reg  <= res_idx_next;
        res_word_reg <= res_word_next;
        res_sum_reg  <= res_sum_next;
        if (cmd.latch) begin
            op_reg     <= op_t'(s_func);
            x_reg      <= s_pos_x;
            y_reg      <= s_pos_y;
            cost_reg   <= s_cost_so_far;
            heur_reg   <= s_heuristic_cost;
            extra_reg  <= s_extra_cost;
            parent_reg <= s_parent_index;
            idx_reg    <= s_node_index;
        end
        if (cmd.load_out) begin
            m_ok_reg     <= res_ok_reg;
            m_idx_reg    <= res_ok_reg ? 9'(res_idx_reg) : 9'd0;
            m_word_reg   <= res_ok_reg ? res_word_reg : '0;
            m_closed_reg <= 10'(closed_reg);
            m_used_reg   <= 10'(used_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = m_ok_reg;
    assign m_found_index    = m_idx_reg;
    assign m_node_x         = m_word_reg.x;
    assign m_node_y         = m_word_reg.y;
    assign m_node_cost      = m_word_reg.cost;
    assign m_node_heuristic = m_word_reg.heur;
    assign m_node_extra     = m_word_reg.extra;
    assign m_node_parent    = m_word_reg.parent;
    assign m_closed_count   = m_closed_reg;
    assign m_used_count     = m_used_reg;

endmodule
